// ===== rtl/core/edc_pkg.sv =====
// ---------------------------------------------------------------------------
// era drift correction table package
// shared types, codes and helpers for the era drift correction table
// ---------------------------------------------------------------------------
`default_nettype none

package edc_pkg;

    localparam int unsigned EPOCH_W   = 32;
    localparam int unsigned CORR_W    = 33;
    localparam int unsigned ERA_LOW_W = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = 5;

    typedef enum logic [1:0] {
        OP_BOOT       = 2'd0,
        OP_CHECKPOINT = 2'd1,
        OP_SYNC       = 2'd2,
        OP_QUERY      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNKNOWN  = 2'd1,
        ST_SKIPPED  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_EPOCH = 1'b0,
        CFG_MAX_EPOCH = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_SYNC_WR,
        S_QEVAL,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_QFIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] era;
        logic [CORR_W-1:0]  delta;
        logic [EPOCH_W-1:0] window_start;
        logic [EPOCH_W-1:0] sync_time;
    } hist_entry_t;

    localparam logic [EPOCH_W-1:0] EPOCH_ALL_ONES = '1;
    localparam logic [EPOCH_W-1:0] MIN_EPOCH_RST  = 32'd1704067200;
    localparam logic [EPOCH_W-1:0] MAX_EPOCH_RST  = 32'd4102444800;

    // t is a signed value two bits wider than an epoch
    function automatic logic plausible(input logic [EPOCH_W+1:0] t,
                                       input logic [EPOCH_W-1:0] lo,
                                       input logic [EPOCH_W-1:0] hi);
        logic in_range;
        in_range = (t[EPOCH_W+1:EPOCH_W] == 2'b00);
        return in_range && (t[EPOCH_W-1:0] >= lo) && (t[EPOCH_W-1:0] < hi);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/edc_if.sv =====
// ---------------------------------------------------------------------------
// era drift correction channels
// request channel and result channel with valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface edc_in_if;
    import edc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    logic [EPOCH_W-1:0]   now_epoch;
    logic [EPOCH_W-1:0]   epoch_before_sync;
    logic [ERA_LOW_W-1:0] query_era_low;
    logic [EPOCH_W-1:0]   recorded_epoch;

    modport source (output valid, operation, now_epoch, epoch_before_sync,
                    query_era_low, recorded_epoch, input ready);
    modport sink   (input valid, operation, now_epoch, epoch_before_sync,
                    query_era_low, recorded_epoch, output ready);
endinterface

interface edc_out_if;
    import edc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic signed [CORR_W-1:0]  correction;
    logic                      restore_valid;
    logic [EPOCH_W-1:0]        restore_epoch;
    logic [EPOCH_W-1:0]        current_era;

    modport source (output valid, status, correction, restore_valid, restore_epoch,
                    current_era, input ready);
    modport sink   (input valid, status, correction, restore_valid, restore_epoch,
                    current_era, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/era_drift_correction_table.sv =====
// ---------------------------------------------------------------------------
// era drift correction table
// era counter, checkpoint and per-era correction history with drift queries
// ---------------------------------------------------------------------------
// boot and checkpoint go straight from the execute state to the result
// sync scans the history one entry a cycle, then writes its slot
// a query scans the history, does one multiply, then runs a
// 32-step restoring divider that produces one quotient bit a cycle
// one request at a time; a new request is taken while a result waits
// asynchronous active-low reset clears era, checkpoint, boot flag and valid bits
`default_nettype none

module era_drift_correction_table #(
    parameter int unsigned HISTORY_DEPTH = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [edc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [edc_pkg::EPOCH_W-1:0]   cfg_data,
    edc_in_if.sink                            in_ch,
    edc_out_if.source                         out_ch
);
    import edc_pkg::*;

    localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

    state_t state_reg, state_next;

    logic [EPOCH_W-1:0] min_epoch_reg, max_epoch_reg;
    logic [EPOCH_W-1:0] era_count_reg, checkpoint_reg;
    logic               booted_reg;
    logic [HISTORY_DEPTH-1:0] hist_valid_reg;
    hist_entry_t        hist_mem [HISTORY_DEPTH];

    // captured request
    logic [1:0]           op_reg;
    logic [EPOCH_W-1:0]   now_reg, before_reg, rec_reg;
    logic [ERA_LOW_W-1:0] qera_reg;

    // scan
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   rd_pos_reg;
    logic               rd_live_reg, rd_valid_reg;
    hist_entry_t        rd_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [EPOCH_W-1:0] lowest_reg;
    hist_entry_t        hit_entry_reg;

    // arithmetic
    logic [2*EPOCH_W-1:0] prod_reg;
    logic [EPOCH_W-1:0]   window_reg, elapsed_reg, mag_reg;
    logic                 neg_reg;
    logic [EPOCH_W:0]     rem_reg;
    logic [EPOCH_W-1:0]   quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // result
    status_t            res_status_reg;
    logic [CORR_W-1:0]  res_corr_reg;
    logic               res_rvalid_reg;
    logic [EPOCH_W-1:0] res_repoch_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [CORR_W-1:0]  out_corr_reg;
    logic               out_rvalid_reg;
    logic [EPOCH_W-1:0] out_repoch_reg, out_era_reg;

    logic accept, out_load, now_ok, rd_hit, scan_sync;
    logic [EPOCH_W+1:0] prev_real;
    logic [EPOCH_W:0]   div_trial;
    logic [CORR_W-1:0]  delta_now;
    logic [EPOCH_W-1:0] rd_era_eff;

    assign accept    = in_ch.valid && in_ch.ready;
    assign now_ok    = plausible({2'b00, now_reg}, min_epoch_reg, max_epoch_reg);
    assign scan_sync = (op_t'(op_reg) == OP_SYNC);
    assign rd_hit    = rd_valid_reg && (scan_sync ? (rd_reg.era == era_count_reg)
                                        : (rd_reg.era[ERA_LOW_W-1:0] == qera_reg));
    assign rd_era_eff = rd_valid_reg ? rd_reg.era : '0;
    assign prev_real = {2'b00, hit_entry_reg.sync_time}
                     + {{1{hit_entry_reg.delta[CORR_W-1]}}, hit_entry_reg.delta};
    assign delta_now = {1'b0, now_reg} - {1'b0, before_reg};
    assign div_trial = {rem_reg[EPOCH_W-1:0], quo_reg[EPOCH_W-1]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (accept) state_next = S_EXEC;
            S_EXEC:
            begin
                case (op_t'(op_reg))
                    OP_SYNC:  state_next = now_ok ? S_SCAN : S_DONE;
                    OP_QUERY: state_next = booted_reg ? S_SCAN : S_DONE;
                    default:  state_next = S_DONE;
                endcase
            end
            S_SCAN:     if (idx_reg == LAST_IDX) state_next = S_DRAIN;
            S_DRAIN:    state_next = scan_sync ? S_SYNC_WR : S_QEVAL;
            S_SYNC_WR:  state_next = S_DONE;
            S_QEVAL:
            begin
                if (hit_reg && !(hit_entry_reg.sync_time != '0 && rec_reg > hit_entry_reg.sync_time)
                    && !(hit_entry_reg.window_start == '0
                         || hit_entry_reg.sync_time <= hit_entry_reg.window_start)
                    && rec_reg > hit_entry_reg.window_start)
                    state_next = S_MUL;
                else
                    state_next = S_DONE;
            end
            S_MUL:      state_next = S_DIV_INIT;
            S_DIV_INIT: state_next = S_DIV;
            S_DIV:      if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) state_next = S_QFIN;
            S_QFIN:     state_next = S_DONE;
            S_DONE:     if (!out_valid_reg || out_ch.ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ch.ready = (state_reg == S_IDLE);
        out_load    = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = out_status_reg;
    assign out_ch.correction    = $signed(out_corr_reg);
    assign out_ch.restore_valid = out_rvalid_reg;
    assign out_ch.restore_epoch = out_repoch_reg;
    assign out_ch.current_era   = out_era_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            min_epoch_reg  <= MIN_EPOCH_RST;
            max_epoch_reg  <= MAX_EPOCH_RST;
            era_count_reg  <= '0;
            checkpoint_reg <= '0;
            booted_reg     <= 1'b0;
            hist_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_MIN_EPOCH: min_epoch_reg <= cfg_data;
                    CFG_MAX_EPOCH: max_epoch_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_EXEC)
            begin
                case (op_t'(op_reg))
                    OP_BOOT:
                    begin
                        booted_reg <= 1'b1;
                        if (!now_ok) era_count_reg <= era_count_reg + 1'b1;
                    end
                    OP_CHECKPOINT: if (now_ok) checkpoint_reg <= now_reg;
                    default: ;
                endcase
            end
            if (state_reg == S_SYNC_WR)
            begin
                hist_valid_reg[slot_reg] <= 1'b1;
                checkpoint_reg           <= now_reg;
            end
            if (out_load)          out_valid_reg <= 1'b1;
            else if (out_ch.ready) out_valid_reg <= 1'b0;
        end
    end

    // history memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SYNC_WR)
        begin
            hist_mem[slot_reg].era          <= era_count_reg;
            hist_mem[slot_reg].delta        <= delta_now;
            hist_mem[slot_reg].sync_time    <= before_reg;
            hist_mem[slot_reg].window_start <=
                (hit_reg && hit_entry_reg.sync_time != '0
                 && plausible(prev_real, min_epoch_reg, max_epoch_reg))
                ? prev_real[EPOCH_W-1:0] : '0;
        end
        rd_reg <= hist_mem[idx_reg];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= in_ch.operation;
            now_reg    <= in_ch.now_epoch;
            before_reg <= in_ch.epoch_before_sync;
            qera_reg   <= in_ch.query_era_low;
            rec_reg    <= in_ch.recorded_epoch;
        end

        rd_valid_reg <= hist_valid_reg[idx_reg];
        rd_pos_reg   <= idx_reg;
        rd_live_reg  <= (state_reg == S_SCAN);

        case (state_reg)
            S_EXEC:
            begin
                idx_reg        <= '0;
                hit_reg        <= 1'b0;
                slot_reg       <= '0;
                lowest_reg     <= EPOCH_ALL_ONES;
                res_status_reg <= ST_OK;
                res_corr_reg   <= '0;
                res_rvalid_reg <= 1'b0;
                res_repoch_reg <= '0;
                case (op_t'(op_reg))
                    OP_BOOT:
                    begin
                        if (!now_ok && plausible({2'b00, checkpoint_reg},
                                                 min_epoch_reg, max_epoch_reg))
                        begin
                            res_rvalid_reg <= 1'b1;
                            res_repoch_reg <= checkpoint_reg;
                        end
                    end
                    OP_QUERY: if (!booted_reg) res_status_reg <= ST_UNKNOWN;
                    default:  if (!now_ok) res_status_reg <= ST_SKIPPED;
                endcase
            end
            S_SCAN:  idx_reg <= idx_reg + 1'b1;
            S_QEVAL:
            begin
                if (!hit_reg)
                    res_status_reg <= ST_UNKNOWN;
                else if (hit_entry_reg.sync_time != '0 && rec_reg > hit_entry_reg.sync_time)
                    res_corr_reg <= '0;
                else if (hit_entry_reg.window_start == '0
                         || hit_entry_reg.sync_time <= hit_entry_reg.window_start)
                    res_corr_reg <= hit_entry_reg.delta;
                else
                    res_corr_reg <= '0;
                window_reg  <= hit_entry_reg.sync_time - hit_entry_reg.window_start;
                elapsed_reg <= rec_reg - hit_entry_reg.window_start;
                neg_reg     <= hit_entry_reg.delta[CORR_W-1];
                mag_reg     <= hit_entry_reg.delta[CORR_W-1]
                             ? EPOCH_W'(-hit_entry_reg.delta) : hit_entry_reg.delta[EPOCH_W-1:0];
            end
            S_MUL:   prod_reg <= mag_reg * elapsed_reg;
            S_DIV_INIT:
            begin
                // dividend is product plus half the window; high part stays below window
                {rem_reg, quo_reg} <= {1'b0, prod_reg} + {34'd0, window_reg[EPOCH_W-1:1]};
                div_cnt_reg        <= '0;
            end
            S_DIV:
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_trial >= {1'b0, window_reg})
                begin
                    rem_reg <= div_trial - {1'b0, window_reg};
                    quo_reg <= {quo_reg[EPOCH_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_trial;
                    quo_reg <= {quo_reg[EPOCH_W-2:0], 1'b0};
                end
            end
            S_QFIN:  res_corr_reg <= neg_reg ? -{1'b0, quo_reg} : {1'b0, quo_reg};
            default: ;
        endcase

        // first hit wins; lowest era only matters while nothing matched
        if (rd_live_reg && !hit_reg)
        begin
            if (rd_hit)
            begin
                hit_reg       <= 1'b1;
                slot_reg      <= rd_pos_reg;
                hit_entry_reg <= rd_reg;
            end
            else if (rd_era_eff < lowest_reg)
            begin
                lowest_reg <= rd_era_eff;
                slot_reg   <= rd_pos_reg;
            end
        end

        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_corr_reg   <= res_corr_reg;
            out_rvalid_reg <= res_rvalid_reg;
            out_repoch_reg <= res_repoch_reg;
            out_era_reg    <= era_count_reg;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == S_IDLE)
        else $error("request taken while busy");

    a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SYNC_WR |=> hist_valid_reg[$past(slot_reg)])
        else $error("sync slot not marked valid");

    a_restore_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && res_rvalid_reg |-> res_status_reg == ST_OK)
        else $error("restore offered with bad status");

    a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV_INIT |=> state_reg == S_DIV && div_cnt_reg == '0)
        else $error("divider not started cleanly");

endmodule

`default_nettype wire
